>>> rtl/core/put_pkg.sv
// ----------------------------------------------------------------------------
// Pending update table package
// Request and status codes, engine states and the structs shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package put_pkg;

  localparam int unsigned MAC_W = 64;
  localparam int unsigned VER_W = 64;
  localparam int unsigned TYP_W = 8;
  localparam int unsigned ATT_W = 16;
  localparam int unsigned CHK_W = 16;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [2:0] {
    REQ_STORE    = 3'd0,
    REQ_CANCEL   = 3'd1,
    REQ_LOOKUP   = 3'd2,
    REQ_COMPLETE = 3'd3,
    REQ_TICK     = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_STORED     = 3'd0,
    ST_NO_ROOM    = 3'd1,
    ST_CANCELLED  = 3'd2,
    ST_FOUND      = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_CPL_NEW    = 3'd5,
    ST_CPL_REPEAT = 3'd6,
    ST_TICK       = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_CAP,
    S_CNT,
    S_REP_RD,
    S_REP_WAIT,
    S_FIN
  } eng_state_t;

  typedef struct packed {
    req_e             req;
    logic [MAC_W-1:0] mac;
    logic [VER_W-1:0] ver;
    logic [TYP_W-1:0] typ;
    logic [ATT_W-1:0] att;
    logic [CHK_W-1:0] chk;
  } cmd_t;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [VER_W-1:0] ver;
    logic [TYP_W-1:0] typ;
    logic [ATT_W-1:0] att;
    logic [CHK_W-1:0] chk;
  } entry_t;

  typedef struct packed {
    status_e          status;
    logic [MAC_W-1:0] mac;
    logic [TYP_W-1:0] typ;
    logic [VER_W-1:0] ver;
    logic [CHK_W-1:0] chk;
    logic             timed_out;
    logic [CNT_W-1:0] pend;
    logic [CNT_W-1:0] noup;
    logic             last;
  } res_t;

endpackage

>>> rtl/core/put_front.sv
// ----------------------------------------------------------------------------
// Pending update table front end
// Accepts requests, drops unknown request types and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module put_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  put_pkg::cmd_t in_cmd,
  output logic          q_valid,
  output put_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import put_pkg::*;

  cmd_t       buf_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       known;
  logic       push;

  always_comb begin
    case (in_cmd.req)
      REQ_STORE, REQ_CANCEL, REQ_LOOKUP, REQ_COMPLETE, REQ_TICK: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready = (fill_r != 2'd2);
  // Unknown request types complete the transfer but never enter the queue.
  assign push     = in_valid && in_ready && known;
  assign q_valid  = (fill_r != 2'd0);
  assign q_cmd    = buf_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ q_pop;
    fill_nxt = fill_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= in_cmd;
    end
  end

endmodule

>>> rtl/core/put_engine.sv
// ----------------------------------------------------------------------------
// Pending update table engine
// Sweeps the slot memory to carry out one request and produces its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module put_engine #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [put_pkg::TYP_W-1:0] no_update_code,
  input  logic                      q_valid,
  input  put_pkg::cmd_t             q_cmd,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output put_pkg::res_t             out_res
);
  import put_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  eng_state_t state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [AW-1:0] p_idx_r, p_idx_nxt;
  logic [TABLE_DEPTH-1:0] live_r, live_nxt;
  logic [TABLE_DEPTH-1:0] rep_r, rep_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [MAC_W-1:0] ack_r, ack_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt, noup_r, noup_nxt;
  status_e       stat_r, stat_nxt;
  entry_t        hold_r, hold_nxt;
  logic          ovld_r, ovld_nxt;
  res_t          ores_r, ores_nxt;

  logic out_free;
  logic scan_done;
  logic match;
  logic rep_here;

  assign out_free  = !ovld_r || out_ready;
  assign scan_done = (cnt_r == LAST_CNT) && !p_vld_r;
  assign match     = p_vld_r && live_r[p_idx_r] && (rd_q.mac == cmd_r.mac);
  assign rep_here  = (cnt_r != LAST_CNT) && rep_r[cnt_r[AW-1:0]];
  assign out_valid = ovld_r;
  assign out_res   = ores_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (q_valid) state_nxt = S_SCAN;
      S_SCAN:     if (scan_done) state_nxt = S_ACT;
      S_ACT:      state_nxt = S_CAP;
      S_CAP:      state_nxt = S_CNT;
      S_CNT: begin
        if (scan_done) state_nxt = (cmd_r.req == REQ_TICK) ? S_REP_RD : S_FIN;
      end
      S_REP_RD: begin
        if (cnt_r == LAST_CNT) state_nxt = S_FIN;
        else if (rep_here) state_nxt = S_REP_WAIT;
      end
      S_REP_WAIT: if (out_free) state_nxt = S_REP_RD;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    p_vld_nxt    = 1'b0;
    p_idx_nxt    = cnt_r[AW-1:0];
    live_nxt     = live_r;
    rep_nxt      = rep_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    ack_nxt      = ack_r;
    pend_nxt     = pend_r;
    noup_nxt     = noup_r;
    stat_nxt     = stat_r;
    hold_nxt     = hold_r;
    ovld_nxt     = ovld_r && !out_ready;
    ores_nxt     = ores_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cnt_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = p_idx_r;
    wr_data      = rd_q;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          rep_nxt  = '0;
          pend_nxt = '0;
          noup_nxt = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r != LAST_CNT) begin
          rd_en     = 1'b1;
          p_vld_nxt = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (p_vld_r) begin
          case (cmd_r.req)
            REQ_CANCEL: if (match) live_nxt[p_idx_r] = 1'b0;
            REQ_TICK: begin
              if (live_r[p_idx_r]) begin
                if (rd_q.att == ATT_W'(1)) begin
                  live_nxt[p_idx_r] = 1'b0;
                  rep_nxt[p_idx_r]  = (rd_q.typ != no_update_code);
                end else begin
                  wr_en       = 1'b1;
                  wr_data.att = rd_q.att - 1'b1;
                  if (rd_q.chk != '0) wr_data.chk = rd_q.chk - 1'b1;
                end
              end
            end
            default: begin
              if (match && !hit_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = p_idx_r;
              end
              if (!live_r[p_idx_r] && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = p_idx_r;
              end
            end
          endcase
        end
      end
      S_ACT: begin
        case (cmd_r.req)
          REQ_STORE: begin
            wr_data = '{mac: cmd_r.mac, ver: cmd_r.ver, typ: cmd_r.typ,
                        att: cmd_r.att, chk: cmd_r.chk};
            wr_addr = hit_r ? hit_idx_r : free_idx_r;
            if (hit_r || free_r) begin
              wr_en             = 1'b1;
              live_nxt[wr_addr] = (cmd_r.att != '0);
              stat_nxt          = ST_STORED;
            end else begin
              stat_nxt = ST_NO_ROOM;
            end
          end
          REQ_CANCEL: stat_nxt = ST_CANCELLED;
          REQ_LOOKUP: begin
            rd_en    = 1'b1;
            rd_addr  = hit_idx_r;
            ack_nxt  = '0;
            stat_nxt = hit_r ? ST_FOUND : ST_NOT_FOUND;
          end
          REQ_COMPLETE: begin
            if (ack_r != cmd_r.mac) begin
              ack_nxt = cmd_r.mac;
              if (hit_r) live_nxt[hit_idx_r] = 1'b0;
              stat_nxt = ST_CPL_NEW;
            end else begin
              stat_nxt = ST_CPL_REPEAT;
            end
          end
          default: stat_nxt = ST_TICK;
        endcase
      end
      S_CAP: begin
        cnt_nxt  = '0;
        hold_nxt = '0;
        if (cmd_r.req == REQ_LOOKUP) begin
          if (hit_r) hold_nxt = rd_q;
          else hold_nxt.typ = no_update_code;
        end
      end
      S_CNT: begin
        if (cnt_r != LAST_CNT) begin
          rd_en     = 1'b1;
          p_vld_nxt = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
        if (p_vld_r && live_r[p_idx_r]) begin
          if (rd_q.typ != no_update_code) pend_nxt = pend_r + 1'b1;
          else noup_nxt = noup_r + 1'b1;
        end
        if (scan_done) cnt_nxt = '0;
      end
      S_REP_RD: begin
        if (rep_here) rd_en = 1'b1;
        else if (cnt_r != LAST_CNT) cnt_nxt = cnt_r + 1'b1;
      end
      S_REP_WAIT: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          ores_nxt = '{status: ST_TICK, mac: rd_q.mac, typ: '0, ver: '0, chk: '0,
                       timed_out: 1'b1, pend: pend_r, noup: noup_r, last: 1'b0};
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          ores_nxt = '{status: stat_r, mac: hold_r.mac, typ: hold_r.typ,
                       ver: hold_r.ver, chk: hold_r.chk, timed_out: 1'b0,
                       pend: pend_r, noup: noup_r, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_vld_r <= 1'b0;
      live_r  <= '0;
      ack_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
      live_r  <= live_nxt;
      ack_r   <= ack_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    p_idx_r    <= p_idx_nxt;
    rep_r      <= rep_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
    noup_r     <= noup_nxt;
    stat_r     <= stat_nxt;
    hold_r     <= hold_nxt;
    ores_r     <= ores_nxt;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

endmodule

>>> rtl/core/pending_update_table_core.sv
// A request is carried out by one sweep of the slot memory, and a second sweep
// counts the occupied slots for the result.
// A tick then walks its report flags and sends one timeout report per expired slot
// whose type differs from no_update_code. The engine serves one request at a time
// and takes the next only after the last result of the current one.
// Reset (synchronous, active low) frees every slot and clears no_update_code.
// ----------------------------------------------------------------------------
// Pending update table core
// Stream front end, request queue and slot engine with a configuration register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pending_update_table_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] tag_mac, [127:64] data_version, [135:128] data_type,
  // [151:136] attempts, [167:152] next_checkin
  input  logic [167:0] in_tdata,
  // [2:0] req_type
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] out_mac, [71:64] out_type, [135:72] out_version,
  // [151:136] out_checkin, [158:152] pending_count,
  // [165:159] no_update_count, [167:166] zero
  output logic [167:0] out_tdata,
  // [2:0] status, [3] timed_out
  output logic [3:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);
  import put_pkg::*;

  logic [TYP_W-1:0] code_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) code_r <= '0;
    else if (cfg_valid) code_r <= cfg_data;
  end

  assign in_cmd = '{req: req_e'(in_tuser), mac: in_tdata[63:0], ver: in_tdata[127:64],
                    typ: in_tdata[135:128], att: in_tdata[151:136],
                    chk: in_tdata[167:152]};

  put_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_cmd  (in_cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  put_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .no_update_code(code_r),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res)
  );

  assign out_tdata = {2'b00, res.noup, res.pend, res.chk, res.ver, res.typ, res.mac};
  assign out_tuser = {res.timed_out, res.status};
  assign out_tlast = res.last;

`ifndef SYNTHESIS
  // A timeout report is never the closing result of a tick.
  a_timeout_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> (out_tuser[2:0] == ST_TICK) && !out_tlast)
    else $error("timeout report malformed");

  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[158:152]) + 32'(out_tdata[165:159]) <= TABLE_DEPTH))
    else $error("slot counts exceed table depth");

  // The queue only drains toward the engine when it holds something.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
